// ===== rtl/core/trigger_safe_burst_indexer_core_assert.svh =====
// Assertion macros shared by the trigger indexer RTL.
`ifndef TRIGGER_SAFE_BURST_INDEXER_CORE_ASSERT_SVH
`define TRIGGER_SAFE_BURST_INDEXER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TSBI_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tsbi: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define TSBI_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tsbi: next-cycle check failed");

`endif

// ===== rtl/core/tsbi_pkg.sv =====
// Package: constants, codes and types of the trigger burst indexer.
`timescale 1ns / 1ps

package tsbi_pkg;

  // Encoder circle; a power of two, so wrapping is a plain truncation.
  localparam int COUNTS_PER_CIRCLE = 8192;
  localparam int CNT_W             = $clog2(COUNTS_PER_CIRCLE);
  localparam int HALF_CIRCLE       = COUNTS_PER_CIRCLE / 2;
  // err * 32 > circle  <=>  err > circle / 32
  localparam int JAM_ERR_LIMIT     = COUNTS_PER_CIRCLE / 32;

  // Field widths
  localparam int POS_W  = 13;
  localparam int CPB_W  = 13;
  localparam int TMO_W  = 16;
  localparam int VEL_W  = 15;
  localparam int SPD_W  = 16;
  localparam int TICK_W = 32;
  localparam int REQ_W  = 3;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_COUNTS_PER_BULLET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_JAM_TIMEOUT       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STALL_VELOCITY    = 2'd2;

  localparam logic [CPB_W-1:0] CPB_RESET = 13'd1024;
  localparam logic [TMO_W-1:0] TMO_RESET = 16'd800;
  localparam logic [VEL_W-1:0] VEL_RESET = 15'd160;

  // Item kinds
  localparam logic KIND_ENTER = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // Event codes
  localparam logic [1:0] EV_NONE       = 2'd0;
  localparam logic [1:0] EV_FRICTION   = 2'd1;
  localparam logic [1:0] EV_ESTOP      = 2'd2;
  localparam logic [1:0] EV_BURST_STOP = 2'd3;

  // State-change requests
  typedef enum logic [REQ_W-1:0] {
    REQ_STAY    = 3'd0,
    REQ_PASSIVE = 3'd1,
    REQ_READY   = 3'd2,
    REQ_BURST   = 3'd3,
    REQ_JAM     = 3'd4
  } req_t;

  typedef struct packed {
    logic [CPB_W-1:0] counts_per_bullet;
    logic [TMO_W-1:0] jam_timeout_ticks;
    logic [VEL_W-1:0] stall_velocity;
  } cfg_t;

  typedef struct packed {
    logic                    kind;
    logic [1:0]              event_req;
    logic                    burst_requested;
    logic [POS_W-1:0]        current_pos;
    logic                    single_allowed;
    logic                    burst_allowed;
    logic signed [SPD_W-1:0] wheel_speed;
    logic [TICK_W-1:0]       tick_now;
  } item_t;

  typedef struct packed {
    logic [CNT_W-1:0]  target_reg;
    logic [TICK_W-1:0] stall_start;
  } state_t;

  typedef struct packed {
    req_t             next_request;
    logic [POS_W-1:0] target_pos;
    logic             stall_timing;
  } result_t;

endpackage

// ===== rtl/core/tsbi_if.sv =====
// Valid/ready channel interfaces for input items and result items.
`timescale 1ns / 1ps

interface tsbi_in_if;
  logic                                      valid;
  logic                                      ready;
  logic                                      kind;
  logic [1:0]                                event_req;
  logic                                      burst_requested;
  logic [tsbi_pkg::POS_W-1:0]                current_pos;
  logic                                      single_allowed;
  logic                                      burst_allowed;
  logic signed [tsbi_pkg::SPD_W-1:0]         wheel_speed;
  logic [tsbi_pkg::TICK_W-1:0]               tick_now;

  modport source (
    output valid, kind, event_req, burst_requested, current_pos,
           single_allowed, burst_allowed, wheel_speed, tick_now,
    input  ready
  );
  modport sink (
    input  valid, kind, event_req, burst_requested, current_pos,
           single_allowed, burst_allowed, wheel_speed, tick_now,
    output ready
  );
endinterface

interface tsbi_out_if;
  logic                       valid;
  logic                       ready;
  logic [tsbi_pkg::REQ_W-1:0] next_request;
  logic [tsbi_pkg::POS_W-1:0] target_pos;
  logic                       stall_timing;

  modport source (
    output valid, next_request, target_pos, stall_timing,
    input  ready
  );
  modport sink (
    input  valid, next_request, target_pos, stall_timing,
    output ready
  );
endinterface

// ===== rtl/core/tsbi_cfg_regs.sv =====
// Configuration registers with their reset values and write decoder.
`timescale 1ns / 1ps

module tsbi_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            we,
  input  logic [tsbi_pkg::CFG_IDX_W-1:0]  index,
  input  logic [tsbi_pkg::CFG_DATA_W-1:0] data,
  output tsbi_pkg::cfg_t                  cfg
);

  // Indexed write; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.counts_per_bullet <= tsbi_pkg::CPB_RESET;
      cfg.jam_timeout_ticks <= tsbi_pkg::TMO_RESET;
      cfg.stall_velocity    <= tsbi_pkg::VEL_RESET;
    end else if (we) begin
      unique case (index)
        tsbi_pkg::REG_COUNTS_PER_BULLET: begin
          cfg.counts_per_bullet <= data[tsbi_pkg::CPB_W-1:0];
        end
        tsbi_pkg::REG_JAM_TIMEOUT: begin
          cfg.jam_timeout_ticks <= data[tsbi_pkg::TMO_W-1:0];
        end
        tsbi_pkg::REG_STALL_VELOCITY: begin
          cfg.stall_velocity <= data[tsbi_pkg::VEL_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/tsbi_step.sv =====
// One control tick: target stepping, request select and jam timer update.
`timescale 1ns / 1ps

module tsbi_step (
  input  tsbi_pkg::item_t   item,
  input  tsbi_pkg::state_t  state,
  input  tsbi_pkg::cfg_t    cfg,
  output tsbi_pkg::state_t  state_next,
  output tsbi_pkg::result_t res
);

  localparam int CNT_W = tsbi_pkg::CNT_W;

  logic [CNT_W-1:0]              pos;
  logic [CNT_W-1:0]              ahead;      // forward distance target -> pos
  logic                          passed;
  logic [CNT_W-1:0]              tgt_step;
  logic [CNT_W-1:0]              err_fwd;    // forward distance pos -> new target
  logic [CNT_W-1:0]              err_mag;
  logic                          err_big;
  logic [tsbi_pkg::SPD_W-1:0]    spd_mag;
  logic                          spd_slow;
  logic                          stalled;
  logic [tsbi_pkg::TICK_W-1:0]   elapsed;
  logic                          timed_out;

  // Position and target distance, all modulo one circle
  assign pos      = CNT_W'(item.current_pos);
  assign ahead    = pos - state.target_reg;
  assign passed   = (ahead != '0) && (ahead < CNT_W'(tsbi_pkg::HALF_CIRCLE));
  assign tgt_step = passed ? state.target_reg + CNT_W'(cfg.counts_per_bullet)
                           : state.target_reg;

  // Wrapped error magnitude against the (possibly stepped) target
  assign err_fwd = tgt_step - pos;
  assign err_mag = (err_fwd > CNT_W'(tsbi_pkg::HALF_CIRCLE)) ? CNT_W'(-err_fwd) : err_fwd;
  assign err_big = err_mag > CNT_W'(tsbi_pkg::JAM_ERR_LIMIT);

  // Speed magnitude; the most negative code maps to 32768
  assign spd_mag  = item.wheel_speed[tsbi_pkg::SPD_W-1] ?
                    tsbi_pkg::SPD_W'(-item.wheel_speed) : item.wheel_speed;
  assign spd_slow = spd_mag < {1'b0, cfg.stall_velocity};
  assign stalled  = err_big && spd_slow;

  assign elapsed   = item.tick_now - state.stall_start;
  assign timed_out = elapsed >= {{(tsbi_pkg::TICK_W - tsbi_pkg::TMO_W){1'b0}},
                                 cfg.jam_timeout_ticks};

  // Request select and state update
  always_comb begin
    state_next       = state;
    res.next_request = tsbi_pkg::REQ_STAY;
    if (item.kind == tsbi_pkg::KIND_ENTER) begin
      state_next.target_reg  = pos;
      state_next.stall_start = '0;
    end else begin
      case (item.event_req) inside
        tsbi_pkg::EV_FRICTION, tsbi_pkg::EV_ESTOP: begin
          res.next_request = tsbi_pkg::REQ_PASSIVE;
        end
        tsbi_pkg::EV_BURST_STOP: begin
          res.next_request = tsbi_pkg::REQ_READY;
        end
        default: begin
          if (!item.burst_requested) begin
            res.next_request = tsbi_pkg::REQ_READY;
          end else if (passed && !item.single_allowed) begin
            // target passed but no heat left: hold, skip the jam check
            res.next_request = tsbi_pkg::REQ_STAY;
          end else begin
            state_next.target_reg = tgt_step;
            if (item.burst_allowed) begin
              res.next_request = tsbi_pkg::REQ_BURST;
            end
            if (stalled) begin
              if (state.stall_start == '0) begin
                state_next.stall_start = item.tick_now;
              end else if (timed_out) begin
                res.next_request = tsbi_pkg::REQ_JAM;
              end
            end else begin
              state_next.stall_start = '0;
            end
          end
        end
      endcase
    end
    res.target_pos   = tsbi_pkg::POS_W'(state_next.target_reg);
    res.stall_timing = (state_next.stall_start != '0);
  end

endmodule

// ===== rtl/core/trigger_safe_burst_indexer_core.sv =====
// Top level of the trigger burst indexer: input register, tick logic, result register.
//
//  channel   dir   handshake       payload
//  in_ch     in    valid/ready     kind, event_req, burst_requested, current_pos,
//                                  single_allowed, burst_allowed, wheel_speed, tick_now
//  out_ch    out   valid/ready     next_request, target_pos, stall_timing
//  cfg_*     in    cfg_we only     cfg_index, cfg_data
//
// One item per cycle sustained while out_ch is not stalled; each result is registered
// (the item sits in the input register, then the tick logic loads the result register).
// The target and jam timer update as the item moves into the result register, so the
// next item in the input register always sees the updated state.
// A stalled output holds the result register and the input register; in_ch.ready drops
// only when both are full and out_ch.ready is low.
// Synchronous reset clears the valid flags, the target and the jam timer; the
// configuration registers return to 1024, 800 and 160.
`timescale 1ns / 1ps
`include "trigger_safe_burst_indexer_core_assert.svh"

module trigger_safe_burst_indexer_core (
  input  logic                            clk,
  input  logic                            rst,
  tsbi_in_if.sink                         in_ch,
  tsbi_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [tsbi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tsbi_pkg::CFG_DATA_W-1:0] cfg_data
);

  tsbi_pkg::cfg_t    cfg;
  tsbi_pkg::item_t   in_item;
  logic              in_valid;
  tsbi_pkg::state_t  state;
  tsbi_pkg::state_t  state_next;
  tsbi_pkg::result_t res;
  tsbi_pkg::result_t out_res;
  logic              out_valid;
  logic              advance;
  logic              fire;

  tsbi_cfg_regs u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  tsbi_step u_step (
    .item       (in_item),
    .state      (state),
    .cfg        (cfg),
    .state_next (state_next),
    .res        (res)
  );

  // Pipeline flow control
  assign advance     = !out_valid || out_ch.ready;
  assign fire        = in_valid && advance;
  assign in_ch.ready = !in_valid || advance;

  // Control and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid          <= 1'b0;
      out_valid         <= 1'b0;
      state.target_reg  <= '0;
      state.stall_start <= '0;
    end else begin
      if (in_ch.ready) begin
        in_valid <= in_ch.valid;
      end
      if (advance) begin
        out_valid <= in_valid;
      end
      if (fire) begin
        state <= state_next;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item.kind            <= in_ch.kind;
      in_item.event_req       <= in_ch.event_req;
      in_item.burst_requested <= in_ch.burst_requested;
      in_item.current_pos     <= in_ch.current_pos;
      in_item.single_allowed  <= in_ch.single_allowed;
      in_item.burst_allowed   <= in_ch.burst_allowed;
      in_item.wheel_speed     <= in_ch.wheel_speed;
      in_item.tick_now        <= in_ch.tick_now;
    end
    if (fire) begin
      out_res <= res;
    end
  end

  // Result channel
  assign out_ch.valid        = out_valid;
  assign out_ch.next_request = out_res.next_request;
  assign out_ch.target_pos   = out_res.target_pos;
  assign out_ch.stall_timing = out_res.stall_timing;

  // Checks
  `TSBI_ASSERT_IMP(a_jam_needs_timer, clk, rst,
    out_valid && (out_res.next_request == tsbi_pkg::REQ_JAM), out_res.stall_timing)
  `TSBI_ASSERT_NXT(a_enter_clears_timer, clk, rst,
    fire && (in_item.kind == tsbi_pkg::KIND_ENTER), state.stall_start == '0)
  `TSBI_ASSERT_NXT(a_state_holds_idle, clk, rst,
    !fire, $stable(state.target_reg) && $stable(state.stall_start))
  `TSBI_ASSERT_IMP(a_ready_when_out_free, clk, rst, !out_valid, in_ch.ready)

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the trigger burst indexer core.
`timescale 1ns / 1ps

module testbench;
  import tsbi_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 300;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tsbi_in_if  in_ch ();
  tsbi_out_if out_ch ();

  trigger_safe_burst_indexer_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Tracks target and jam timer, holds the results still owed by the block
  class indexer_scoreboard;
    logic [CPB_W-1:0]  bullet_counts;
    logic [TMO_W-1:0]  jam_ticks;
    logic [VEL_W-1:0]  stall_speed;
    logic [CNT_W-1:0]  target;
    logic [TICK_W-1:0] stall_since;
    result_t           pending_results[$];
    int                mismatches;

    function new();
      bullet_counts = CPB_RESET;
      jam_ticks     = TMO_RESET;
      stall_speed   = VEL_RESET;
      target        = '0;
      stall_since   = '0;
      mismatches    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_COUNTS_PER_BULLET: bullet_counts = data[CPB_W-1:0];
        REG_JAM_TIMEOUT:       jam_ticks     = data[TMO_W-1:0];
        REG_STALL_VELOCITY:    stall_speed   = data[VEL_W-1:0];
        default: ;
      endcase
    endfunction

    // One control tick or enter item; updates target and timer
    function result_t step_indexer(item_t it);
      result_t          r;
      logic [CNT_W-1:0] ahead;
      logic [CNT_W-1:0] lag;
      int               err_mag;
      int               spd_mag;
      logic             stalled;
      r.next_request = REQ_STAY;
      if (it.kind == KIND_ENTER) begin
        target      = it.current_pos;
        stall_since = '0;
      end else if (it.event_req == EV_FRICTION || it.event_req == EV_ESTOP) begin
        r.next_request = REQ_PASSIVE;
      end else if (it.event_req == EV_BURST_STOP || !it.burst_requested) begin
        r.next_request = REQ_READY;
      end else begin
        ahead = it.current_pos - target;
        // target passed but no heat left: hold, no jam check
        if (!(ahead != 0 && ahead < HALF_CIRCLE && !it.single_allowed)) begin
          if (ahead != 0 && ahead < HALF_CIRCLE) target = target + bullet_counts;
          if (it.burst_allowed) r.next_request = REQ_BURST;
          lag     = target - it.current_pos;
          err_mag = int'(lag);
          if (err_mag > COUNTS_PER_CIRCLE - err_mag) err_mag = COUNTS_PER_CIRCLE - err_mag;
          spd_mag = $signed(it.wheel_speed);
          if (spd_mag < 0) spd_mag = -spd_mag;
          stalled = (err_mag * 32 > COUNTS_PER_CIRCLE) && (spd_mag < int'(stall_speed));
          if (!stalled) begin
            stall_since = '0;
          end else if (stall_since == '0) begin
            stall_since = it.tick_now;  // a zero tick leaves the timer idle
          end else if (TICK_W'(it.tick_now - stall_since) >= jam_ticks) begin
            r.next_request = REQ_JAM;
          end
        end
      end
      r.target_pos   = target;
      r.stall_timing = (stall_since != '0);
      return r;
    endfunction

    function void note_item(item_t it);
      pending_results.push_back(step_indexer(it));
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: expected none actual req %0d target %0d timing %0d",
                 $time, got.next_request, got.target_pos, got.stall_timing);
        return;
      end
      want = pending_results.pop_front();
      if (got.next_request !== want.next_request) begin
        mismatches++;
        $display("%0t: next_request expected %0d actual %0d", $time,
                 want.next_request, got.next_request);
      end
      if (got.target_pos !== want.target_pos) begin
        mismatches++;
        $display("%0t: target_pos expected %0d actual %0d", $time,
                 want.target_pos, got.target_pos);
      end
      if (got.stall_timing !== want.stall_timing) begin
        mismatches++;
        $display("%0t: stall_timing expected %0d actual %0d", $time,
                 want.stall_timing, got.stall_timing);
      end
    endfunction
  endclass

  indexer_scoreboard sb;
  bit                idle_on;
  bit                long_hold_req;
  logic [TICK_W-1:0] tick_clock;
  result_t           seen;
  int                cycle_count;

  always #2 clk = ~clk;

  // Result sink: random stall bursts plus one long hold-off on request
  initial begin
    int stall_left;
    int hold_left;
    stall_left   = 0;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        out_ch.ready = 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD - 1;
        out_ch.ready  = 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready = 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        stall_left   = $urandom_range(1, 15) - 1;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // Compare every accepted result
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      seen.next_request = req_t'(out_ch.next_request);
      seen.target_pos   = out_ch.target_pos;
      seen.stall_timing = out_ch.stall_timing;
      sb.check_result(seen);
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic item_t make_item(logic kind, logic [1:0] ev, logic breq,
                                      logic [POS_W-1:0] pos, logic sgl, logic bok,
                                      logic [SPD_W-1:0] spd, logic [TICK_W-1:0] now);
    item_t it;
    it.kind            = kind;
    it.event_req       = ev;
    it.burst_requested = breq;
    it.current_pos     = pos;
    it.single_allowed  = sgl;
    it.burst_allowed   = bok;
    it.wheel_speed     = spd;
    it.tick_now        = now;
    return it;
  endfunction

  // Drive one item after an optional gap; note it once taken
  task automatic send_item(input item_t it);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 15);
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.kind            = it.kind;
    in_ch.event_req       = it.event_req;
    in_ch.burst_requested = it.burst_requested;
    in_ch.current_pos     = it.current_pos;
    in_ch.single_allowed  = it.single_allowed;
    in_ch.burst_allowed   = it.burst_allowed;
    in_ch.wheel_speed     = it.wheel_speed;
    in_ch.tick_now        = it.tick_now;
    in_ch.valid           = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_item(it);
  endtask

  // Drop valid and let every owed result arrive, then idle quietly
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_config(input int cpb, input int tmo, input int vel);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = REG_COUNTS_PER_BULLET;
    cfg_data  = CFG_DATA_W'(cpb);
    sb.write_reg(REG_COUNTS_PER_BULLET, CFG_DATA_W'(cpb));
    @(negedge clk);
    cfg_index = REG_JAM_TIMEOUT;
    cfg_data  = CFG_DATA_W'(tmo);
    sb.write_reg(REG_JAM_TIMEOUT, CFG_DATA_W'(tmo));
    @(negedge clk);
    cfg_index = REG_STALL_VELOCITY;
    cfg_data  = CFG_DATA_W'(vel);
    sb.write_reg(REG_STALL_VELOCITY, CFG_DATA_W'(vel));
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Tick of a firing sequence: position mostly near the target, wheel mostly slow, ticks mostly rising
  function automatic item_t make_sequence_tick();
    item_t            it;
    int               off;
    int               sp;
    int               lim;
    int               step_max;
    int               r;
    logic [CNT_W-1:0] p;
    case ($urandom_range(0, 5))
      0:       off = 0;
      1:       off = $urandom_range(1, 300);
      2:       off = -int'($urandom_range(1, 700));
      3:       off = $urandom;
      4:       off = HALF_CIRCLE + int'($urandom_range(0, 2)) - 1;
      default: off = $urandom_range(257, 2000);
    endcase
    p   = sb.target + off[CNT_W-1:0];
    lim = 2 * int'(sb.stall_speed);
    if (lim > 32767) lim = 32767;
    if ($urandom_range(0, 3) == 0) begin
      sp = $urandom;
    end else begin
      sp = $urandom_range(0, lim);
      if ($urandom_range(0, 1) == 1) sp = -sp;
    end
    step_max = int'(sb.jam_ticks) / 3 + 1;
    r        = $urandom_range(0, 39);
    if (r == 0)      tick_clock = $urandom;
    else if (r == 1) tick_clock = '0;
    else if (r == 2) tick_clock = 32'hFFFF_FFFF - $urandom_range(0, step_max);
    else             tick_clock = tick_clock + $urandom_range(1, step_max);
    case ($urandom_range(0, 19))
      0:       it.event_req = EV_FRICTION;
      1:       it.event_req = EV_ESTOP;
      2:       it.event_req = EV_BURST_STOP;
      default: it.event_req = EV_NONE;
    endcase
    it.kind            = ($urandom_range(0, 29) == 0) ? KIND_ENTER : KIND_TICK;
    it.burst_requested = ($urandom_range(0, 15) != 0);
    it.current_pos     = p;
    it.single_allowed  = ($urandom_range(0, 4) != 0);
    it.burst_allowed   = ($urandom_range(0, 1) == 1);
    it.wheel_speed     = sp[SPD_W-1:0];
    it.tick_now        = tick_clock;
    return it;
  endfunction

  task automatic run_phase(input int cpb, input int tmo, input int vel, input int n_items,
                           input bit idles, input bit hold);
    int               sent;
    int               len;
    logic [95:0]      raw;
    item_t            it;
    wait_drained();
    apply_config(cpb, tmo, vel);
    idle_on       = idles;
    long_hold_req = hold;
    sent          = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 4) == 0) begin
        // noise item
        raw = {$urandom, $urandom, $urandom};
        it  = raw[$bits(item_t)-1:0];
        send_item(it);
        sent++;
      end else begin
        len = $urandom_range(8, 40);
        send_item(make_item(KIND_ENTER, EV_NONE, 1'b1, POS_W'($urandom), 1'b1, 1'b1,
                            '0, tick_clock));
        sent++;
        repeat (len) begin
          send_item(make_sequence_tick());
          sent++;
        end
      end
    end
  endtask

  // Short directed pass under reset configuration
  task automatic run_directed();
    send_item(make_item(KIND_ENTER, EV_NONE,       1'b1, 13'd0,    1'b1, 1'b1, 16'd0, 32'd0));
    send_item(make_item(KIND_TICK,  EV_FRICTION,   1'b1, 13'd0,    1'b1, 1'b1, 16'd0, 32'd1));
    send_item(make_item(KIND_TICK,  EV_ESTOP,      1'b1, 13'd0,    1'b1, 1'b1, 16'd0, 32'd2));
    send_item(make_item(KIND_TICK,  EV_BURST_STOP, 1'b1, 13'd0,    1'b1, 1'b1, 16'd0, 32'd3));
    send_item(make_item(KIND_TICK,  EV_NONE,       1'b0, 13'd0,    1'b1, 1'b1, 16'd0, 32'd4));
    // passed the target with no heat
    send_item(make_item(KIND_TICK,  EV_NONE,       1'b1, 13'd100,  1'b0, 1'b1, 16'd0, 32'd5));
    // advance and stall at tick zero: timer stays idle
    send_item(make_item(KIND_TICK,  EV_NONE,       1'b1, 13'd100,  1'b1, 1'b1, 16'd0, 32'd0));
    send_item(make_item(KIND_TICK,  EV_NONE,       1'b1, 13'd100,  1'b1, 1'b1, 16'd0, 32'd1000));
    send_item(make_item(KIND_TICK,  EV_NONE,       1'b1, 13'd100,  1'b1, 1'b1, 16'd0, 32'd1500));
    send_item(make_item(KIND_TICK,  EV_NONE,       1'b1, 13'd100,  1'b1, 1'b1, 16'd0, 32'd1800));
    // fast wheel clears the timer
    send_item(make_item(KIND_TICK,  EV_NONE,       1'b1, 13'd100,  1'b1, 1'b1, 16'h8000,
                        32'd1900));
    send_item(make_item(KIND_TICK,  EV_NONE,       1'b1, 13'd100,  1'b1, 1'b0, 16'h7FFF,
                        32'd2000));
    // jam across the tick wrap
    send_item(make_item(KIND_TICK,  EV_NONE,       1'b1, 13'd100,  1'b1, 1'b1, -16'sd159,
                        32'hFFFF_FF00));
    send_item(make_item(KIND_TICK,  EV_NONE,       1'b1, 13'd100,  1'b1, 1'b1, 16'd159,
                        32'h0000_0300));
    // target wraps past the top of the circle
    send_item(make_item(KIND_ENTER, EV_NONE,       1'b1, 13'd8191, 1'b0, 1'b0, 16'd0,
                        32'hFFFF_FFFF));
    send_item(make_item(KIND_TICK,  EV_NONE,       1'b1, 13'd0,    1'b1, 1'b1, 16'd0, 32'd5));
    // half a circle ahead does not count as passed, one less does
    send_item(make_item(KIND_ENTER, EV_NONE,       1'b1, 13'd0,    1'b1, 1'b1, 16'd0, 32'd6));
    send_item(make_item(KIND_TICK,  EV_NONE,       1'b1, 13'd4096, 1'b1, 1'b1, 16'd0, 32'd10));
    send_item(make_item(KIND_TICK,  EV_NONE,       1'b1, 13'd4095, 1'b1, 1'b1, 16'd0, 32'd11));
    send_item(make_item(KIND_TICK,  EV_NONE,       1'b1, 13'd1224, 1'b1, 1'b0, 16'd0, 32'd12));
    send_item(make_item(KIND_TICK,  EV_NONE,       1'b1, 13'd2048, 1'b1, 1'b1, 16'd0,
                        32'hFFFF_FFFF));
    send_item(make_item(KIND_TICK,  EV_NONE,       1'b1, 13'd8191, 1'b0, 1'b1, 16'hFFFF,
                        32'hAAAA_5555));
  endtask

  // Main sequence
  initial begin
    sb                    = new();
    clk                   = 1'b0;
    rst                   = 1'b1;
    idle_on               = 1'b1;
    long_hold_req         = 1'b0;
    tick_clock            = '0;
    cfg_we                = 1'b0;
    cfg_index             = REG_COUNTS_PER_BULLET;
    cfg_data              = '0;
    in_ch.valid           = 1'b0;
    in_ch.kind            = KIND_ENTER;
    in_ch.event_req       = EV_NONE;
    in_ch.burst_requested = 1'b0;
    in_ch.current_pos     = '0;
    in_ch.single_allowed  = 1'b0;
    in_ch.burst_allowed   = 1'b0;
    in_ch.wheel_speed     = '0;
    in_ch.tick_now        = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    run_directed();
    run_phase(8191, 1,     32767, 275, 1'b1, 1'b1);
    run_phase(1,    65535, 1,     275, 1'b1, 1'b0);
    run_phase(1024, 5,     160,   275, 1'b1, 1'b0);
    run_phase($urandom_range(1, 8191), $urandom_range(1, 65535), $urandom_range(1, 32767),
              275, 1'b1, 1'b0);
    run_phase(300,  40,    2000,  275, 1'b1, 1'b0);
    run_phase($urandom_range(1, 8191), $urandom_range(1, 200), $urandom_range(1, 32767),
              275, 1'b1, 1'b0);
    run_phase(4096, 16,    800,   275, 1'b0, 1'b0);

    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
